FILE: hdl/tilt_kalman_angle_bias_defines.svh
// Assertion macros shared by the checker file of the tilt filter.
// No dependencies.
`ifndef TILT_KALMAN_ANGLE_BIAS_DEFINES_SVH
`define TILT_KALMAN_ANGLE_BIAS_DEFINES_SVH

// Concurrent assertion, masked while reset is high.
`define TKA_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tka assertion failed");

// Concurrent assertion that is also checked across reset.
`define TKA_ASSERT_NR(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("tka assertion failed");

`endif

FILE: hdl/tka_pkg.sv
// Shared types, constants and helpers of the tilt Kalman filter.
// No dependencies.
package tka_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_P         = 28;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int NUM_W          = 32 + FRAC_P;   // dividend magnitude width
  localparam logic signed [63:0] ONE_P = 64'sd1 <<< FRAC_P;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_STEP   = 3'd0,
    CFG_ANGLE_NOISE = 3'd1,
    CFG_BIAS_NOISE  = 3'd2,
    CFG_MEAS_NOISE  = 3'd3,
    CFG_UPDATE_MODE = 3'd4,
    CFG_START_ANGLE = 3'd5,
    CFG_START_BIAS  = 3'd6
  } cfg_idx_t;

  localparam logic MODE_CONT = 1'b0;
  localparam logic MODE_DISC = 1'b1;

  // Datapath operations, in the order the controller runs them.
  typedef enum logic [3:0] {
    OP_ANG_PRED  = 4'd0,
    OP_PAA_PRED  = 4'd1,
    OP_PAB_PRED  = 4'd2,
    OP_PBA_PRED  = 4'd3,
    OP_PBB_PRED  = 4'd4,
    OP_DIV_K0    = 4'd5,
    OP_DIV_K1    = 4'd6,
    OP_PAA_UPD   = 4'd7,
    OP_PAB_UPD   = 4'd8,
    OP_PBA_UPD   = 4'd9,
    OP_PBB_UPD   = 4'd10,
    OP_ANG_UPD   = 4'd11,
    OP_BIAS_UPD  = 4'd12
  } op_t;

  typedef struct packed {
    logic [30:0]        time_step;
    logic [30:0]        angle_noise;
    logic [30:0]        bias_noise;
    logic [30:0]        meas_noise;
    logic               update_mode;
    logic signed [31:0] start_angle;
    logic signed [31:0] start_bias;
  } cfg_t;

  typedef struct packed {
    logic load;       // capture input transaction, apply restart
    logic mul;        // register product of selected operands
    logic acc;        // round, add into or subtract from destination, saturate
    logic delta;      // form Pdot terms and innovation
    logic div_set;    // start a gain division
    logic div_step;   // one quotient bit
    logic div_store;  // write gain
    op_t  op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_stat_t;

  // Clamp to a signed value of rb bits, returned sign-extended to 32 bits.
  function automatic logic signed [31:0] sat_reg(input logic signed [63:0] x,
                                                 input int rb);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (rb - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (x > hi) return hi[31:0];
    if (x < lo) return lo[31:0];
    return x[31:0];
  endfunction

endpackage

FILE: hdl/tka_in_if.sv
// Input channel of the tilt filter: one gyro sample, one measured angle and a restart flag.
// No dependencies.
interface tka_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] gyro_rate;
  logic signed [31:0] meas_angle;
  logic               restart;

  modport source (output valid, gyro_rate, meas_angle, restart, input ready);
  modport sink   (input valid, gyro_rate, meas_angle, restart, output ready);
endinterface

FILE: hdl/tka_out_if.sv
// Result channel of the tilt filter: state estimate and covariance.
// No dependencies.
interface tka_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] angle_est;
  logic signed [31:0] bias_est;
  logic signed [31:0] cov_aa;
  logic signed [31:0] cov_ab;
  logic signed [31:0] cov_ba;
  logic signed [31:0] cov_bb;

  modport source (output valid, angle_est, bias_est, cov_aa, cov_ab, cov_ba, cov_bb,
                  input ready);
  modport sink   (input valid, angle_est, bias_est, cov_aa, cov_ab, cov_ba, cov_bb,
                  output ready);
endinterface

FILE: hdl/tilt_kalman_angle_bias.sv
// Top level of the two-state tilt Kalman filter (angle and gyro bias).
// Depends on tka_pkg, tka_in_if, tka_out_if, tka_ctrl and tka_datapath.
//
// Usage:
//   in_ch  : valid/ready channel, one transaction per IMU sample
//            (gyro_rate Q16.16, meas_angle Q16.16, restart flag).
//   out_ch : valid/ready channel, one transaction per sample carrying the
//            updated angle, bias and the four covariance terms.
//   cfg_*  : write-only register port, one register per cycle when cfg_we.
//            Write only while no sample is in flight.
// Flow: one sample is processed at a time, and no new transaction is
//   taken until the result has left on out_ch. A sample runs accept, the
//   angle prediction, Pdot forming, the covariance predictions, two gain
//   divisions by a 60-step restoring divider, the covariance, angle and
//   bias updates and the output state; 11 passes go through the shared
//   multiplier. A non-positive innovation variance skips the divider steps.
// Reset: state returns to angle = bias = 0 and identity covariance, all
//   configuration registers to their defaults, both channels idle.
// Stall: a result stays on out_ch until taken; in_ch.ready stays low until
//   then, so nothing is lost.
module tilt_kalman_angle_bias #(
  parameter int DATA_WIDTH = tka_pkg::DATA_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [tka_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tka_pkg::CFG_DATA_W-1:0]   cfg_data,
  tka_in_if.sink                           in_ch,
  tka_out_if.source                        out_ch
);
  import tka_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.time_step   <= 31'd4026532;
      cfg.angle_noise <= 31'd268435;
      cfg.bias_noise  <= 31'd805306;
      cfg.meas_noise  <= 31'd134217728;
      cfg.update_mode <= MODE_CONT;
      cfg.start_angle <= '0;
      cfg.start_bias  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TIME_STEP:   cfg.time_step   <= cfg_data[30:0];
        CFG_ANGLE_NOISE: cfg.angle_noise <= cfg_data[30:0];
        CFG_BIAS_NOISE:  cfg.bias_noise  <= cfg_data[30:0];
        CFG_MEAS_NOISE:  cfg.meas_noise  <= cfg_data[30:0];
        CFG_UPDATE_MODE: cfg.update_mode <= cfg_data[0];
        CFG_START_ANGLE: cfg.start_angle <= signed'(cfg_data);
        CFG_START_BIAS:  cfg.start_bias  <= signed'(cfg_data);
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  tka_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // results are read straight from the state registers, which hold
  // still while the controller waits in its output state
  tka_datapath #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd        (cmd),
    .stat       (stat),
    .gyro_in    (in_ch.gyro_rate),
    .meas_in    (in_ch.meas_angle),
    .restart_in (in_ch.restart),
    .angle      (out_ch.angle_est),
    .bias       (out_ch.bias_est),
    .paa        (out_ch.cov_aa),
    .pab        (out_ch.cov_ab),
    .pba        (out_ch.cov_ba),
    .pbb        (out_ch.cov_bb)
  );

endmodule

FILE: hdl/tka_ctrl.sv
// Sequencer of the tilt filter: steps the datapath through predict and update.
// Depends on tka_pkg.
module tka_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  tka_pkg::dp_stat_t  stat,
  output tka_pkg::dp_cmd_t   cmd
);
  import tka_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_ACC, S_DELTA, S_DSET, S_DIV, S_STORE, S_OUT
  } state_t;

  state_t state;
  op_t    op;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_ANG_PRED;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op    <= OP_ANG_PRED;
            state <= S_MUL;
          end
        end
        S_MUL: state <= S_ACC;
        S_ACC: begin
          if (op == OP_ANG_PRED) begin
            op    <= OP_PAA_PRED;
            state <= S_DELTA;
          end else if (op == OP_PBB_PRED) begin
            op    <= OP_DIV_K0;
            state <= S_DSET;
          end else if (op == OP_BIAS_UPD) begin
            state <= S_OUT;
          end else begin
            op    <= op_t'(op + 4'd1);
            state <= S_MUL;
          end
        end
        S_DELTA: state <= S_MUL;
        S_DSET:  state <= S_DIV;
        S_DIV: begin
          if (stat.div_done) state <= S_STORE;
        end
        S_STORE: begin
          if (op == OP_DIV_K0) begin
            op    <= OP_DIV_K1;
            state <= S_DSET;
          end else begin
            op    <= OP_PAA_UPD;
            state <= S_MUL;
          end
        end
        S_OUT: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd           = '0;
    cmd.op        = op;
    cmd.load      = in_valid && in_ready;
    cmd.mul       = (state == S_MUL);
    cmd.acc       = (state == S_ACC);
    cmd.delta     = (state == S_DELTA);
    cmd.div_set   = (state == S_DSET);
    cmd.div_step  = (state == S_DIV);
    cmd.div_store = (state == S_STORE);
  end

endmodule

FILE: hdl/tka_datapath.sv
// Datapath of the tilt filter: state, covariance, shared multiplier, serial divider.
// Depends on tka_pkg.
module tka_datapath #(
  parameter int DATA_WIDTH = tka_pkg::DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  tka_pkg::cfg_t      cfg,
  input  tka_pkg::dp_cmd_t   cmd,
  output tka_pkg::dp_stat_t  stat,
  input  logic signed [31:0] gyro_in,
  input  logic signed [31:0] meas_in,
  input  logic               restart_in,
  output logic signed [31:0] angle,
  output logic signed [31:0] bias,
  output logic signed [31:0] paa,
  output logic signed [31:0] pab,
  output logic signed [31:0] pba,
  output logic signed [31:0] pbb
);
  import tka_pkg::*;

  localparam int REG_BITS = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
  localparam int CNT_W    = $clog2(NUM_W + 1);

  logic signed [31:0] gyro, meas;
  logic signed [31:0] d00, d01, d10, d11;
  logic signed [33:0] err;
  logic signed [31:0] t0, t1, k0, k1;
  logic signed [65:0] prod;

  // divider
  logic [NUM_W-1:0] dq;
  logic [31:0]      rem;
  logic [31:0]      dvs;
  logic             dneg, dzero;
  logic [CNT_W-1:0] cnt;

  // multiply operand select
  logic signed [33:0] opa;
  logic signed [31:0] opb;
  logic signed [31:0] base;
  logic               sub;

  always_comb begin
    opa  = '0;
    opb  = '0;
    base = '0;
    sub  = 1'b0;
    case (cmd.op)
      OP_ANG_PRED: begin
        opa  = 34'(gyro) - 34'(bias);
        opb  = signed'({1'b0, cfg.time_step});
        base = angle;
      end
      OP_PAA_PRED: begin opa = 34'(d00); opb = signed'({1'b0, cfg.time_step}); base = paa; end
      OP_PAB_PRED: begin opa = 34'(d01); opb = signed'({1'b0, cfg.time_step}); base = pab; end
      OP_PBA_PRED: begin opa = 34'(d10); opb = signed'({1'b0, cfg.time_step}); base = pba; end
      OP_PBB_PRED: begin opa = 34'(d11); opb = signed'({1'b0, cfg.time_step}); base = pbb; end
      OP_PAA_UPD:  begin opa = 34'(k0); opb = t0; base = paa; sub = 1'b1; end
      OP_PAB_UPD:  begin opa = 34'(k0); opb = t1; base = pab; sub = 1'b1; end
      OP_PBA_UPD:  begin opa = 34'(k1); opb = t0; base = pba; sub = 1'b1; end
      OP_PBB_UPD:  begin opa = 34'(k1); opb = t1; base = pbb; sub = 1'b1; end
      OP_ANG_UPD:  begin opa = err; opb = k0; base = angle; end
      OP_BIAS_UPD: begin opa = err; opb = k1; base = bias; end
      default: ;
    endcase
  end

  // round half up, floor shift, accumulate, saturate
  logic signed [65:0] prod_r;
  logic signed [37:0] rnd;
  logic signed [39:0] sum;
  logic signed [31:0] acc_val;

  always_comb begin
    prod_r  = prod + (66'sd1 <<< (FRAC_P - 1));
    rnd     = prod_r[65:FRAC_P];
    sum     = sub ? (40'(base) - 40'(rnd)) : (40'(base) + 40'(rnd));
    acc_val = sat_reg(64'(sum), REG_BITS);
  end

  // innovation variance and division operands
  logic signed [33:0] e_n;
  logic signed [31:0] num;
  logic [32:0]        trial;
  logic signed [NUM_W:0] qs;
  logic signed [31:0] k_val;

  always_comb begin
    e_n   = 34'(paa) + signed'({3'b000, cfg.meas_noise});
    num   = (cmd.op == OP_DIV_K0) ? paa : pba;
    trial = {rem, dq[NUM_W-1]};
    qs    = dneg ? -signed'({1'b0, dq}) : signed'({1'b0, dq});
    k_val = dzero ? 32'sd0 : sat_reg(64'(qs), REG_BITS);
  end

  assign stat.div_done = dzero || (cnt == CNT_W'(NUM_W));

  always_ff @(posedge clk) begin
    if (rst) begin
      angle <= '0;
      bias  <= '0;
      paa   <= sat_reg(ONE_P, REG_BITS);
      pab   <= '0;
      pba   <= '0;
      pbb   <= sat_reg(ONE_P, REG_BITS);
    end else begin
      if (cmd.load && restart_in) begin
        angle <= sat_reg(64'(cfg.start_angle), REG_BITS);
        bias  <= sat_reg(64'(cfg.start_bias), REG_BITS);
        paa   <= sat_reg(ONE_P, REG_BITS);
        pab   <= '0;
        pba   <= '0;
        pbb   <= sat_reg(ONE_P, REG_BITS);
      end else if (cmd.acc) begin
        case (cmd.op)
          OP_ANG_PRED, OP_ANG_UPD: angle <= acc_val;
          OP_BIAS_UPD:             bias  <= acc_val;
          OP_PAA_PRED, OP_PAA_UPD: paa   <= acc_val;
          OP_PAB_PRED, OP_PAB_UPD: pab   <= acc_val;
          OP_PBA_PRED, OP_PBA_UPD: pba   <= acc_val;
          OP_PBB_PRED, OP_PBB_UPD: pbb   <= acc_val;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      gyro <= gyro_in;
      meas <= meas_in;
    end
    if (cmd.mul) prod <= opa * 66'(opb);
    if (cmd.delta) begin
      if (cfg.update_mode == MODE_CONT) begin
        d00 <= sat_reg(64'(signed'({1'b0, cfg.angle_noise})) - 64'(pab) - 64'(pba), REG_BITS);
        d01 <= sat_reg(-64'(pbb), REG_BITS);
        d10 <= sat_reg(-64'(pbb), REG_BITS);
      end else begin
        d00 <= sat_reg(64'(pbb) + 64'(signed'({1'b0, cfg.angle_noise})), REG_BITS);
        d01 <= '0;
        d10 <= '0;
      end
      d11 <= sat_reg(64'(signed'({1'b0, cfg.bias_noise})), REG_BITS);
      err <= 34'(meas) - 34'(angle);
    end
    if (cmd.div_set) begin
      t0    <= paa;
      t1    <= pab;
      dzero <= (e_n <= 34'sd0);
      dvs   <= e_n[31:0];
      dneg  <= num[31];
      dq    <= {(num[31] ? 32'(-num) : 32'(num)), {FRAC_P{1'b0}}};
      rem   <= '0;
      cnt   <= '0;
    end else if (cmd.div_step && !stat.div_done) begin
      if (trial >= {1'b0, dvs}) begin
        rem <= 32'(trial - {1'b0, dvs});
        dq  <= {dq[NUM_W-2:0], 1'b1};
      end else begin
        rem <= trial[31:0];
        dq  <= {dq[NUM_W-2:0], 1'b0};
      end
      cnt <= cnt + CNT_W'(1);
    end
    if (cmd.div_store) begin
      if (cmd.op == OP_DIV_K0) k0 <= k_val;
      else                     k1 <= k_val;
    end
  end

endmodule

FILE: hdl/tka_checker.sv
// Port-level checks of the tilt filter, bound to the top level.
// Depends on tilt_kalman_angle_bias_defines.svh and tilt_kalman_angle_bias.
`include "tilt_kalman_angle_bias_defines.svh"

module tka_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] angle_est
);
  `TKA_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(angle_est))
  `TKA_ASSERT(a_one_at_a_time, clk, rst, out_valid |-> !in_ready)
  `TKA_ASSERT(a_no_instant_result, clk, rst, in_valid && in_ready |=> !out_valid)
  `TKA_ASSERT_NR(a_reset_quiet, clk, rst |=> !out_valid && in_ready)
endmodule

bind tilt_kalman_angle_bias tka_checker u_tka_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .angle_est (out_ch.angle_est)
);
